/* src/tklt_pkg.sv */
// Package for the top-k leader tracker: sizes, payload structs, state codes.
// No dependencies.
`default_nettype none
package tklt_pkg;
  localparam int Leaders   = 8;
  localparam int PopMax    = 256;
  localparam int WindowMax = 64;
  localparam int RingRows  = WindowMax + 1;
  localparam int RowW      = $clog2(RingRows);
  localparam int LdrW      = $clog2(Leaders);
  localparam int CntW      = 4;
  localparam int IdxW      = $clog2(PopMax);

  localparam logic KIND_MEMBER = 1'b0;
  localparam logic KIND_END    = 1'b1;

  localparam logic CFG_STALL_WINDOW = 1'b0;
  localparam logic CFG_SETTLE_EPS   = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [7:0]         member_index;
    logic signed [31:0] fitness;
    logic               fitness_invalid;
    logic [15:0]        position_tag;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         insert_rank;
    logic               pbest_updated;
    logic               best_updated;
    logic signed [31:0] global_fit;
    logic               best_valid;
    logic [15:0]        best_tag;
    logic [3:0]         leader_count;
    logic               leader_dropped;
  } out_item_t;

  // score: ok bit and value
  typedef struct packed {
    logic               ok;
    logic signed [31:0] val;
  } score_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;

  function automatic logic beats(score_t a, score_t b);
    return a.ok && (!b.ok || (a.val < b.val));
  endfunction
endpackage
`default_nettype wire

/* src/tklt_pbest_mem.sv */
// Personal-best memory, registered synchronous read, one write port.
// Depends on tklt_pkg.
`default_nettype none
module tklt_pbest_mem
  import tklt_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [IdxW-1:0] waddr,
  input  wire score_t          wdata,
  input  wire logic [IdxW-1:0] raddr,
  output score_t               rdata
);
  score_t mem [PopMax];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/tklt_hist_mem.sv */
// Leader history ring: one row of Leaders scores per end mark.
// Depends on tklt_pkg.
`default_nettype none
module tklt_hist_mem
  import tklt_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [RowW-1:0] waddr,
  input  wire score_t [Leaders-1:0] wdata,
  input  wire logic [RowW-1:0] raddr,
  output score_t [Leaders-1:0] rdata
);
  score_t [Leaders-1:0] mem [RingRows];

  // write a full row, read one row registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/top_k_leader_tracker.sv */
// Top level of the top-k leader tracker: control, leader list, best registers.
// Depends on tklt_pkg, tklt_pbest_mem and tklt_hist_mem.
// Each item goes through accept (memory reads issue), update and result in turn.
// The personal-best memory and the history ring each have a registered read.
// After reset a clearing pass sweeps all PopMax (256) entries of the
// personal-best memory before the first item is accepted. One result is
// produced for each item; results wait in an output register.
`default_nettype none
module top_k_leader_tracker
  import tklt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  state_t state_r, state_nxt;
  logic [IdxW:0] clr_r, clr_nxt;
  in_item_t item_r;
  out_item_t res_r, res_nxt;
  logic [6:0]  stall_window_r;
  logic [15:0] settle_epsilon_r;
  score_t [Leaders-1:0] lfit_r, lfit_nxt;
  logic [Leaders-1:0][15:0] ltag_r, ltag_nxt;
  logic [CntW-1:0] act_r, act_nxt;
  score_t gb_r, gb_nxt;
  logic [15:0] gbtag_r, gbtag_nxt;
  logic [15:0] iter_r, iter_nxt;
  logic [RowW-1:0] ring_r, ring_nxt;

  // memory ports
  logic pb_we;
  logic [IdxW-1:0] pb_waddr;
  score_t pb_wdata, pb_rdata;
  logic h_we;
  score_t [Leaders-1:0] h_wdata, h_rdata;
  logic [RowW-1:0] h_raddr;
  logic [6:0] s_win;

  tklt_pbest_mem u_pb (
    .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
    .raddr(in_data.member_index), .rdata(pb_rdata)
  );

  tklt_hist_mem u_hist (
    .clk(clk), .we(h_we), .waddr(ring_r), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  // clamp window and locate the old row
  always_comb begin
    logic [RowW:0] t;
    s_win = (stall_window_r > 7'(WindowMax)) ? 7'(WindowMax) : stall_window_r;
    t = {1'b0, ring_r} + (RowW+1)'(RingRows) - (RowW+1)'(s_win);
    if (t >= (RowW+1)'(RingRows)) begin
      t = t - (RowW+1)'(RingRows);
    end
    h_raddr = t[RowW-1:0];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_window_r   <= 7'd5;
      settle_epsilon_r <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STALL_WINDOW: stall_window_r <= cfg_wdata[6:0];
        CFG_SETTLE_EPS:   settle_epsilon_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = res_r;

  // sequencer and update
  always_comb begin
    score_t f, cur, old;
    logic found, stall;
    logic [CntW-1:0] rank;
    logic [LdrW-1:0] last;
    logic signed [33:0] d;
    state_nxt = state_r;
    clr_nxt   = clr_r;
    lfit_nxt  = lfit_r;
    ltag_nxt  = ltag_r;
    act_nxt   = act_r;
    gb_nxt    = gb_r;
    gbtag_nxt = gbtag_r;
    iter_nxt  = iter_r;
    ring_nxt  = ring_r;
    res_nxt   = res_r;
    pb_we     = 1'b0;
    pb_waddr  = item_r.member_index;
    pb_wdata  = '0;
    h_we      = 1'b0;
    h_wdata   = lfit_r;
    f.ok  = !item_r.fitness_invalid;
    f.val = item_r.fitness;
    found = 1'b0;
    stall = 1'b0;
    rank  = CntW'(Leaders);
    last  = LdrW'(act_r - 1'b1);
    cur   = lfit_r[last];
    // a zero window compares against the row being written now
    old   = (s_win == 7'd0) ? cur : h_rdata[last];
    d     = '0;
    case (state_r)
      ST_CLEAR: begin
        pb_we    = 1'b1;
        pb_waddr = clr_r[IdxW-1:0];
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == (IdxW+1)'(PopMax - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_nxt = '0;
        if (item_r.kind == KIND_MEMBER) begin
          // personal best
          if (beats(f, pb_rdata)) begin
            pb_we    = 1'b1;
            pb_wdata = f;
            res_nxt.pbest_updated = 1'b1;
          end
          // sorted insert into active leaders
          for (int k = 0; k < Leaders; k++) begin
            if (!found && (k < act_r) && beats(f, lfit_r[k])) begin
              found = 1'b1;
              rank  = CntW'(k);
            end
          end
          if (found) begin
            for (int l = 1; l < Leaders; l++) begin
              if ((l > rank) && (l < act_r)) begin
                lfit_nxt[l] = lfit_r[l-1];
                ltag_nxt[l] = ltag_r[l-1];
              end
            end
            lfit_nxt[rank[LdrW-1:0]] = f;
            ltag_nxt[rank[LdrW-1:0]] = item_r.position_tag;
          end
          res_nxt.insert_rank = rank;
          if (beats(f, gb_r)) begin
            gb_nxt    = f;
            gbtag_nxt = item_r.position_tag;
            res_nxt.best_updated = 1'b1;
          end
        end else begin
          // record leaders; inactive slots copy the old row read from the ring
          h_we = 1'b1;
          for (int k = 0; k < Leaders; k++) begin
            h_wdata[k] = (k < act_r) ? lfit_r[k] : h_rdata[k];
          end
          res_nxt.insert_rank = CntW'(Leaders);
          if (iter_r >= 16'(s_win) + 16'd1) begin
            if (!cur.ok) begin
              stall = 1'b1;
            end else if (old.ok) begin
              d = 34'(cur.val) - 34'(old.val);
              if (d < 0) begin
                d = -d;
              end
              stall = d < $signed({18'd0, settle_epsilon_r});
            end
          end
          if (stall && (act_r > 1)) begin
            act_nxt = act_r - 1'b1;
            res_nxt.leader_dropped = 1'b1;
          end
          if (iter_r != 16'hFFFF) begin
            iter_nxt = iter_r + 1'b1;
          end
          ring_nxt = (ring_r == RowW'(RingRows - 1)) ? '0 : ring_r + 1'b1;
        end
        res_nxt.best_valid   = gb_nxt.ok;
        res_nxt.global_fit   = gb_nxt.ok ? gb_nxt.val : '0;
        res_nxt.best_tag     = gb_nxt.ok ? gbtag_nxt : '0;
        res_nxt.leader_count = act_nxt;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // history read data reused for inactive slots: row written is ring_r,
  // but the row read is the old row; keep inactive slots as recorded there
  // is harmless since inactive slots are never tested.

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      lfit_r  <= '0;
      ltag_r  <= '0;
      act_r   <= CntW'(Leaders);
      gb_r    <= '0;
      gbtag_r <= '0;
      iter_r  <= '0;
      ring_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      lfit_r  <= lfit_nxt;
      ltag_r  <= ltag_nxt;
      act_r   <= act_nxt;
      gb_r    <= gb_nxt;
      gbtag_r <= gbtag_nxt;
      iter_r  <= iter_nxt;
      ring_r  <= ring_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    res_r <= res_nxt;
  end
endmodule
`default_nettype wire
